>>> hw/rtl/cbs_pkg.sv
// Package for the cell balance selector: register indexes, field widths
// and default sizing. No dependencies.
`default_nettype none

package cbs_pkg;

  localparam int unsigned CellCountDef = 16;
  localparam int unsigned TableDepth   = 16;
  localparam int unsigned VoltW        = 16;
  localparam int unsigned MaskW        = 16;
  localparam int unsigned IdxW         = 4;
  localparam int unsigned RegIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned InDataW      = 40;
  localparam int unsigned OutDataW     = 16;

  typedef enum logic [RegIdxW-1:0] {
    REG_BAL_EN   = 3'd0,
    REG_LO_BOUND = 3'd1,
    REG_HI_BOUND = 3'd2,
    REG_DELTA    = 3'd3,
    REG_VALID    = 3'd4,
    REG_TEST     = 3'd5,
    REG_PERIOD   = 3'd6
  } reg_idx_e;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdTick   = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/cell_balance_selector_unit.sv
// Cell balance selector top level: sample table, tick sequencer, output register.
// Depends on cbs_pkg.
//
// Sample transfers store one cell voltage and return one result one cycle
// after the input transfer. A tick transfer that runs an evaluation or a
// test-mode selection walks the cell voltage table one position per cycle
// through a single-port table and one shared compare unit: it covers
// min(CellCount, 16) positions in the walk state, between the prime and
// done states, before the result is offered. Other ticks answer in the cycle
// after the input transfer. One item is in flight at a time;
// s_axis_tready is low from the input transfer until the result transfer
// completes.
`default_nettype none

module cell_balance_selector_unit #(
  parameter int unsigned CellCount = cbs_pkg::CellCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // cell_index[3:0], cell_volt[19:4], data_ready[20], test_mode[21],
  // charger_in[22], min_volt[38:23], zero[39]
  input  wire logic [cbs_pkg::InDataW-1:0]   s_axis_tdata,
  // cmd
  input  wire logic                          s_axis_tuser,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // commanded_mask[15:0]
  output      logic [cbs_pkg::OutDataW-1:0]  m_axis_tdata,
  // apply_pulse
  output      logic                          m_axis_tuser,
  input  wire logic                          cfg_we_i,
  input  wire logic [cbs_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  wire logic [cbs_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned Depth = (CellCount < cbs_pkg::TableDepth) ?
                                  CellCount : cbs_pkg::TableDepth;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AddrW-1:0] LastPos = AddrW'(Depth - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_DONE,
    ST_OUT
  } state_e;

  // config registers
  logic                        bal_en_q;
  logic [cbs_pkg::VoltW-1:0]   lo_bound_q, hi_bound_q, delta_q;
  logic [cbs_pkg::MaskW-1:0]   valid_q, test_q;
  logic [cbs_pkg::VoltW-1:0]   period_q;

  // block state
  state_e                      state_q;
  logic [cbs_pkg::MaskW-1:0]   sent_q;
  logic [cbs_pkg::VoltW-1:0]   timer_q;
  logic                        odd_phase_q;
  logic                        pulse_q;

  // walk state
  logic                        test_walk_q;
  logic [cbs_pkg::VoltW-1:0]   minv_q;
  logic [AddrW-1:0]            pos_q;
  logic [cbs_pkg::MaskW-1:0]   sel_q;
  logic                        ord_q;
  logic [cbs_pkg::MaskW-1:0]   acc_q, alt_q;

  // cell table
  logic [cbs_pkg::VoltW-1:0]   volts_mem [Depth];
  logic [cbs_pkg::VoltW-1:0]   rd_q;

  // input fields
  logic                        in_cmd;
  logic [cbs_pkg::IdxW-1:0]    in_idx;
  logic [cbs_pkg::VoltW-1:0]   in_volt;
  logic                        in_ready, in_test, in_charger;
  logic [cbs_pkg::VoltW-1:0]   in_minv;
  logic                        in_xfer, out_xfer;

  assign in_cmd     = s_axis_tuser;
  assign in_idx     = s_axis_tdata[3:0];
  assign in_volt    = s_axis_tdata[19:4];
  assign in_ready   = s_axis_tdata[20];
  assign in_test    = s_axis_tdata[21];
  assign in_charger = s_axis_tdata[22];
  assign in_minv    = s_axis_tdata[38:23];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = sent_q;
  assign m_axis_tuser  = pulse_q;

  // shared compare unit, one table position per cycle
  logic                        pop, par_hit, cmp_hit;
  logic [cbs_pkg::VoltW-1:0]   diff;
  logic [cbs_pkg::MaskW-1:0]   walk_mask, test_sel;
  logic [AddrW-1:0]            pos_next, rd_addr;
  logic                        wr_en;

  assign pop      = |(valid_q & sel_q);
  assign par_hit  = (ord_q == odd_phase_q);
  assign diff     = (rd_q >= minv_q) ? (rd_q - minv_q) : (minv_q - rd_q);
  assign cmp_hit  = (rd_q > lo_bound_q) && (rd_q < hi_bound_q) && (diff > delta_q);
  assign pos_next = (pos_q == LastPos) ? '0 : pos_q + AddrW'(1);
  assign rd_addr  = (state_q == ST_WALK) ? pos_next : '0;
  assign wr_en    = in_xfer && (in_cmd == cbs_pkg::CmdSample) &&
                    ({1'b0, in_idx} < (cbs_pkg::IdxW + 1)'(Depth));
  assign test_sel = (acc_q != '0) ? acc_q : alt_q;
  assign walk_mask = test_walk_q ? test_sel : acc_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      volts_mem[in_idx[AddrW-1:0]] <= in_volt;
    end
    rd_q <= volts_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_en_q   <= 1'b0;
      lo_bound_q <= '0;
      hi_bound_q <= '1;
      delta_q    <= '0;
      valid_q    <= '1;
      test_q     <= '0;
      period_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbs_pkg::REG_BAL_EN:   bal_en_q   <= cfg_wdata_i[0];
        cbs_pkg::REG_LO_BOUND: lo_bound_q <= cfg_wdata_i;
        cbs_pkg::REG_HI_BOUND: hi_bound_q <= cfg_wdata_i;
        cbs_pkg::REG_DELTA:    delta_q    <= cfg_wdata_i;
        cbs_pkg::REG_VALID:    valid_q    <= cfg_wdata_i;
        cbs_pkg::REG_TEST:     test_q     <= cfg_wdata_i;
        cbs_pkg::REG_PERIOD:   period_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sent_q      <= '0;
      timer_q     <= '0;
      odd_phase_q <= 1'b0;
      pulse_q     <= 1'b0;
      test_walk_q <= 1'b0;
      minv_q      <= '0;
      pos_q       <= '0;
      sel_q       <= '0;
      ord_q       <= 1'b0;
      acc_q       <= '0;
      alt_q       <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            pulse_q     <= 1'b0;
            minv_q      <= in_minv;
            test_walk_q <= in_test;
            pos_q       <= '0;
            sel_q       <= cbs_pkg::MaskW'(1);
            ord_q       <= 1'b0;
            acc_q       <= '0;
            alt_q       <= '0;
            state_q     <= ST_OUT;
            if (in_cmd == cbs_pkg::CmdTick) begin
              priority if (!in_ready) begin
                state_q <= ST_OUT;
              end else if (in_test) begin
                state_q <= ST_PRIME;
              end else if (!bal_en_q || !in_charger) begin
                pulse_q <= (sent_q != '0);
                sent_q  <= '0;
              end else if (period_q <= timer_q) begin
                timer_q <= '0;
                state_q <= ST_PRIME;
              end else begin
                timer_q <= timer_q + cbs_pkg::VoltW'(1);
              end
            end
          end
        end
        ST_PRIME: begin
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          if (pop) begin
            ord_q <= ~ord_q;
            if (test_walk_q) begin
              if (!ord_q) acc_q <= acc_q | (sel_q & test_q);
              else        alt_q <= alt_q | (sel_q & test_q);
            end else if (par_hit && cmp_hit) begin
              acc_q <= acc_q | sel_q;
            end
          end
          sel_q <= sel_q << 1;
          pos_q <= pos_next;
          if (pos_q == LastPos) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!test_walk_q) begin
            odd_phase_q <= ~odd_phase_q;
          end
          pulse_q <= (walk_mask != sent_q);
          sent_q  <= walk_mask;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_xfer) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_walk_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> $onehot(sel_q))
    else $error("walk select not one-hot");

  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result is pending");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready && (m_axis_tvalid || state_q == ST_PRIME))
    else $error("sequencer did not start after input transfer");

  a_mask_stable_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(sent_q) && $stable(odd_phase_q))
    else $error("state moved while result stalled");
`endif

endmodule

`default_nettype wire

>>> test/tb_cell_balance_selector_unit.sv
// Testbench for cell_balance_selector_unit: drives sample and tick transfers,
// predicts results with a behavioral copy of the selector or takes them from
// the directed rows, and checks them. Depends on cbs_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb_cell_balance_selector_unit;

  localparam int unsigned NumDirected  = 25;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseItems   = 128;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned StallLimit   = 2000;

  typedef struct packed {
    logic                      cmd;
    logic [cbs_pkg::IdxW-1:0]  cell_index;
    logic [cbs_pkg::VoltW-1:0] cell_volt;
    logic                      data_ready;
    logic                      test_mode;
    logic                      charger_in;
    logic [cbs_pkg::VoltW-1:0] min_volt;
  } bal_item_t;

  typedef struct packed {
    logic [cbs_pkg::MaskW-1:0] mask;
    logic                      pulse;
  } bal_result_t;

  typedef struct packed {
    logic                      en;
    logic [cbs_pkg::VoltW-1:0] lo_bound;
    logic [cbs_pkg::VoltW-1:0] hi_bound;
    logic [cbs_pkg::VoltW-1:0] delta;
    logic [cbs_pkg::MaskW-1:0] valid;
    logic [cbs_pkg::MaskW-1:0] test;
    logic [15:0]               period;
  } bal_cfg_t;

  typedef struct {
    bal_item_t   item;
    logic        typed;
    bal_result_t want;
  } stim_row_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [cbs_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         s_axis_tuser  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [cbs_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         cfg_we_i      = 1'b0;
  logic [cbs_pkg::RegIdxW-1:0]  cfg_idx_i     = '0;
  logic [cbs_pkg::CfgDataW-1:0] cfg_wdata_i   = '0;

  // selector model state
  bal_cfg_t                  cfg_q;
  logic [cbs_pkg::VoltW-1:0] volt_tbl [cbs_pkg::TableDepth];
  logic [cbs_pkg::MaskW-1:0] work_mask;
  logic [cbs_pkg::MaskW-1:0] sent_mask_q;
  logic [15:0]               tick_count;
  logic                      odd_phase_q;

  bal_result_t mask_fifo [$];
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned n_samples      = 0;
  int unsigned n_ticks        = 0;
  int unsigned n_evals        = 0;
  int unsigned n_results      = 0;
  int unsigned n_pulses       = 0;
  int unsigned n_settings     = 0;
  int unsigned n_errors       = 0;

  cell_balance_selector_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ordinal parity among populated cells, not position parity
  function automatic logic [cbs_pkg::MaskW-1:0] parity_cells(input logic par);
    logic [cbs_pkg::MaskW-1:0] m;
    logic                      ord;
    m   = '0;
    ord = 1'b0;
    for (int p = 0; p < cbs_pkg::TableDepth; p++) begin
      if (p < cbs_pkg::CellCountDef && cfg_q.valid[p]) begin
        if (ord == par) m[p] = 1'b1;
        ord = ~ord;
      end
    end
    return m;
  endfunction

  function automatic logic [cbs_pkg::MaskW-1:0] pick_cells(
      input logic [cbs_pkg::VoltW-1:0] minv);
    logic [cbs_pkg::MaskW-1:0] m;
    logic [cbs_pkg::VoltW-1:0] v;
    logic [cbs_pkg::VoltW-1:0] d;
    logic                      ord;
    m   = '0;
    ord = 1'b0;
    for (int p = 0; p < cbs_pkg::TableDepth; p++) begin
      if (p < cbs_pkg::CellCountDef && cfg_q.valid[p]) begin
        v = volt_tbl[p];
        d = (v >= minv) ? v - minv : minv - v;
        if (ord == odd_phase_q && v > cfg_q.lo_bound && v < cfg_q.hi_bound &&
            d > cfg_q.delta) m[p] = 1'b1;
        ord = ~ord;
      end
    end
    return m;
  endfunction

  function automatic bal_result_t balance_step(input bal_item_t it);
    logic [cbs_pkg::MaskW-1:0] e;
    logic [cbs_pkg::MaskW-1:0] o;
    logic                      send;
    logic                      fire;
    send = 1'b0;
    fire = 1'b0;
    if (it.cmd == cbs_pkg::CmdSample) begin
      volt_tbl[it.cell_index] = it.cell_volt;
    end else if (!it.data_ready) begin
      work_mask = '0;
    end else if (it.test_mode) begin
      e = cfg_q.test & parity_cells(1'b0);
      o = cfg_q.test & parity_cells(1'b1);
      work_mask = (e != '0) ? e : o;
      send = 1'b1;
    end else if (!cfg_q.en || !it.charger_in) begin
      work_mask = '0;
      send = 1'b1;
    end else if (cfg_q.period <= tick_count) begin
      tick_count  = '0;
      work_mask   = pick_cells(it.min_volt);
      odd_phase_q = ~odd_phase_q;
      send = 1'b1;
      n_evals++;
    end else begin
      tick_count = tick_count + 16'd1;
    end
    if (send) begin
      fire        = (work_mask != sent_mask_q);
      sent_mask_q = work_mask;
    end
    return '{mask: sent_mask_q, pulse: fire};
  endfunction

  function automatic bal_item_t mk_sample(input logic [cbs_pkg::IdxW-1:0] idx,
                                          input logic [cbs_pkg::VoltW-1:0] volt);
    bal_item_t it;
    it.cmd        = cbs_pkg::CmdSample;
    it.cell_index = idx;
    it.cell_volt  = volt;
    it.data_ready = 1'($urandom_range(1));
    it.test_mode  = 1'($urandom_range(1));
    it.charger_in = 1'($urandom_range(1));
    it.min_volt   = 16'($urandom);
    return it;
  endfunction

  function automatic bal_item_t mk_tick(input logic rdy, input logic tst, input logic chg,
                                        input logic [cbs_pkg::VoltW-1:0] minv);
    bal_item_t it;
    it.cmd        = cbs_pkg::CmdTick;
    it.cell_index = 4'($urandom);
    it.cell_volt  = 16'($urandom);
    it.data_ready = rdy;
    it.test_mode  = tst;
    it.charger_in = chg;
    it.min_volt   = minv;
    return it;
  endfunction

  // mostly pack-like voltages, now and then any 16-bit value
  function automatic logic [cbs_pkg::VoltW-1:0] rand_mv(input int unsigned lo,
                                                        input int unsigned hi);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic bal_item_t rand_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return mk_sample(4'($urandom), rand_mv(2800, 4300));
    if (r < 85) return mk_tick(1'b1, 1'b0, 1'b1, rand_mv(2800, 3600));
    return mk_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   16'($urandom));
  endfunction

  function automatic bal_cfg_t rand_cfg();
    bal_cfg_t c;
    c.en       = 1'b1;
    c.lo_bound = 16'($urandom_range(3300, 2800));
    c.hi_bound = 16'($urandom_range(4300, 3800));
    c.delta    = 16'($urandom_range(200));
    c.valid    = ($urandom_range(3) == 0) ? 16'($urandom) : 16'hFFFF;
    c.test     = 16'($urandom);
    c.period   = 16'($urandom_range(3));
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got 0x%0h want 0x%0h at result %0d", what, got, want, n_results);
    n_errors++;
  endtask

  task automatic write_reg(input cbs_pkg::reg_idx_e idx,
                           input logic [cbs_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic apply_cfg(input bal_cfg_t c);
    write_reg(cbs_pkg::REG_BAL_EN,   {15'd0, c.en});
    write_reg(cbs_pkg::REG_LO_BOUND, c.lo_bound);
    write_reg(cbs_pkg::REG_HI_BOUND, c.hi_bound);
    write_reg(cbs_pkg::REG_DELTA,    c.delta);
    write_reg(cbs_pkg::REG_VALID,    c.valid);
    write_reg(cbs_pkg::REG_TEST,     c.test);
    write_reg(cbs_pkg::REG_PERIOD,   c.period);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_q = c;
    n_settings++;
  endtask

  task automatic push_item(input bal_item_t it, input logic typed, input bal_result_t want);
    bal_result_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {1'b0, it.min_volt, it.charger_in, it.test_mode, it.data_ready,
                      it.cell_volt, it.cell_index};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = balance_step(it);
    mask_fifo.push_back(typed ? want : pred);
    if (it.cmd == cbs_pkg::CmdSample) n_samples++;
    else n_ticks++;
  endtask

  // hold off the sender until every result is back, then let the unit go quiet
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (mask_fifo.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    bal_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (m_axis_tuser) n_pulses++;
      if (mask_fifo.size() == 0) begin
        report_mismatch("unexpected result, mask", 32'(m_axis_tdata), 0);
      end else begin
        exp_r = mask_fifo.pop_front();
        if (m_axis_tdata !== exp_r.mask)
          report_mismatch("commanded_mask", 32'(m_axis_tdata), 32'(exp_r.mask));
        if (m_axis_tuser !== exp_r.pulse)
          report_mismatch("apply_pulse", 32'(m_axis_tuser), 32'(exp_r.pulse));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               quiet_cycles, mask_fifo.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [NumDirected];
    bal_cfg_t  c;

    cfg_q       = '{en: 1'b0, lo_bound: 16'h0, hi_bound: 16'hFFFF, delta: 16'h0,
                    valid: 16'hFFFF, test: 16'h0, period: 16'h0};
    work_mask   = '0;
    sent_mask_q = '0;
    tick_count  = '0;
    odd_phase_q = 1'b0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every cell written before the first tick; nothing sent yet
    for (int i = 0; i < 16; i++) begin
      rows[i] = '{mk_sample(4'(i), (i == 0) ? 16'h0 : (i == 1) ? 16'hFFFF :
                            16'(3000 + 100 * i)), 1'b1, '{mask: 16'h0, pulse: 1'b0}};
    end
    // not ready wins over test mode
    rows[16] = '{mk_tick(1'b0, 1'b1, 1'b1, 16'h0),    1'b1, '{mask: 16'h0, pulse: 1'b0}};
    rows[17] = '{mk_tick(1'b1, 1'b1, 1'b0, 16'h0),    1'b0, '0};
    // charger absent clears the mask
    rows[18] = '{mk_tick(1'b1, 1'b0, 1'b0, 16'h0),    1'b1, '{mask: 16'h0, pulse: 1'b1}};
    // timer below period: count only
    rows[19] = '{mk_tick(1'b1, 1'b0, 1'b1, 16'h0),    1'b1, '{mask: 16'h0, pulse: 1'b0}};
    rows[20] = '{mk_tick(1'b1, 1'b0, 1'b1, 16'h0),    1'b0, '0};
    rows[21] = '{mk_tick(1'b1, 1'b0, 1'b1, 16'h0),    1'b0, '0};
    rows[22] = '{mk_tick(1'b1, 1'b0, 1'b1, 16'hFFFF), 1'b0, '0};
    rows[23] = '{mk_sample(4'd1, 16'd3333),           1'b0, '0};
    rows[24] = '{mk_tick(1'b1, 1'b1, 1'b1, 16'h8000), 1'b0, '0};

    apply_cfg('{en: 1'b1, lo_bound: 16'h0, hi_bound: 16'hFFFF, delta: 16'h0,
                valid: 16'hFFFF, test: 16'h00F0, period: 16'd1});
    for (int i = 0; i < NumDirected; i++) push_item(rows[i].item, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      unique case (ph)
        1: c = '{en: 1'b1, lo_bound: 16'h0, hi_bound: 16'hFFFF, delta: 16'h0,
                 valid: 16'hFFFF, test: 16'hFFFF, period: 16'h0};
        2: c = '{en: 1'b0, lo_bound: 16'hFFFF, hi_bound: 16'h0, delta: 16'hFFFF,
                 valid: 16'h0, test: 16'hFFFF, period: 16'hFFFF};
        5: begin
          c       = rand_cfg();
          c.valid = 16'hFFFF;
          c.test  = 16'hAAAA;
        end
        6: begin
          c    = rand_cfg();
          c.en = 1'b0;
        end
        default: c = rand_cfg();
      endcase
      apply_cfg(c);
      unique case (ph % 4)
        1: src_idle_pct = 63;
        2: sink_stall_pct = 63;
        3: begin
          src_idle_pct   = 28;
          sink_stall_pct = 28;
        end
        default: ;
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 3 && n == PhaseItems / 2) settle();
        push_item(rand_item(), 1'b0, '0);
      end
    end

    settle();
    $display("ran %0d samples and %0d ticks across %0d register settings and 4 idle mixes",
             n_samples, n_ticks, n_settings);
    $display("checked %0d results: %0d evaluations, %0d apply pulses, %0d mismatches",
             n_results, n_evals, n_pulses, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
